@@ rtl/srr_pkg.sv @@
// Shared types and constants for the sprite row run to rectangle unit.
// Holds the register map, the configuration bundle and the rectangle descriptor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

    // Default geometry limits, handed to the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Descriptor index fields are 12 bits, wide enough for a sprite of up to 4096 columns.
    localparam int COORD_W = 12;

    // Screen coordinate width of the result fields.
    localparam int SCREEN_W = 20;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_SCALE        = 3'd2,
        REG_FLIP_X       = 3'd3,
        REG_SPRITE_WIDTH = 3'd4,
        REG_MIN_OPACITY  = 3'd5,
        REG_FIRST_ROW    = 3'd6,
        REG_ROW_COUNT    = 3'd7
    } srr_reg_e;

    typedef struct packed {
        logic signed [14:0] origin_x;
        logic signed [14:0] origin_y;
        logic [7:0]         scale;
        logic               flip_x;
        logic [10:0]        sprite_width;
        logic [7:0]         min_opacity;
        logic [9:0]         first_row;
        logic [10:0]        row_count;
    } srr_cfg_t;

    // One closed run, already mirrored, in source units.
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] trow;
        logic [15:0]        color;
        logic [7:0]         opacity;
        logic               last;
    } srr_desc_t;

    // Rectangles caused by one request: count 0..2, d0 goes out first.
    typedef struct packed {
        logic [1:0] cnt;
        srr_desc_t  d0;
        srr_desc_t  d1;
    } srr_pair_t;

endpackage

`default_nettype wire

@@ rtl/sprite_row_run_to_rectangles_unit.sv @@
// Top level of the sprite row run to rectangle unit.
// Instantiates srr_cfg_regs, srr_run_tracker and srr_rect_emit; uses srr_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  handshake                 payload
//  s_        in         s_valid / s_ready         pixel_opacity, pixel_color, end_of_sprite
//  m_        out        m_valid / m_ready         x_left..y_bottom, fill_color/opacity, last
//  apb       in/out     psel, penable, pready     paddr, pwdata, prdata
//
//  One pixel request per cycle while s_ready holds; run state updates in the accept cycle.
//  A rectangle reaches m_ through the descriptor holder and then the result register.
//  A pixel that closes two rectangles sends them out one after the other and drops
//  s_ready while the two-entry descriptor holder is full. Reset is
//  synchronous on aresetn and needs no clearing pass. A stalled m_ready holds the
//  result and backs up s_ready.

module sprite_row_run_to_rectangles_unit #(
    parameter int MAX_WIDTH  = srr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = srr_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [srr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [srr_pkg::DATA_W-1:0]   pwdata,
    output logic      [srr_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    // Pixel requests
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [7:0]                   s_pixel_opacity,
    input  wire logic [15:0]                  s_pixel_color,
    input  wire logic                         s_end_of_sprite,
    // Rectangle results
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [srr_pkg::SCREEN_W-1:0] m_x_left,
    output logic signed [srr_pkg::SCREEN_W-1:0] m_y_top,
    output logic signed [srr_pkg::SCREEN_W-1:0] m_x_right,
    output logic signed [srr_pkg::SCREEN_W-1:0] m_y_bottom,
    output logic [15:0]                       m_fill_color,
    output logic [7:0]                        m_fill_opacity,
    output logic                              m_last_of_item
);

    srr_pkg::srr_cfg_t  cfg;
    srr_pkg::srr_pair_t pair;
    logic               s_fire;

    // Advance the run tracker only on an accepted request.
    assign s_fire = s_valid && s_ready;

    srr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srr_run_tracker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .fire          (s_fire),
        .pixel_opacity (s_pixel_opacity),
        .pixel_color   (s_pixel_color),
        .end_of_sprite (s_end_of_sprite),
        .pair          (pair)
    );

    // Hold descriptors for the current request, drop empty ones, emit in order.
    srr_rect_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .pair_in        (pair),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_x_left       (m_x_left),
        .m_y_top        (m_y_top),
        .m_x_right      (m_x_right),
        .m_y_bottom     (m_y_bottom),
        .m_fill_color   (m_fill_color),
        .m_fill_opacity (m_fill_opacity),
        .m_last_of_item (m_last_of_item)
    );

endmodule

`default_nettype wire

@@ rtl/srr_cfg_regs.sv @@
// APB-style configuration register file for the sprite run unit.
// Depends on srr_pkg for the register map and the configuration bundle.
`timescale 1ns / 1ps
`default_nettype none

module srr_cfg_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [srr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [srr_pkg::DATA_W-1:0] pwdata,
    output logic      [srr_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output srr_pkg::srr_cfg_t               cfg
);

    srr_pkg::srr_cfg_t cfg_reg;
    srr_pkg::srr_cfg_t cfg_next;
    srr_pkg::srr_reg_e reg_sel;
    logic              wr_en;

    assign reg_sel = srr_pkg::srr_reg_e'(paddr[srr_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                srr_pkg::REG_ORIGIN_X:     cfg_next.origin_x     = $signed(pwdata[14:0]);
                srr_pkg::REG_ORIGIN_Y:     cfg_next.origin_y     = $signed(pwdata[14:0]);
                srr_pkg::REG_SCALE:        cfg_next.scale        = pwdata[7:0];
                srr_pkg::REG_FLIP_X:       cfg_next.flip_x       = pwdata[0];
                srr_pkg::REG_SPRITE_WIDTH: cfg_next.sprite_width = pwdata[10:0];
                srr_pkg::REG_MIN_OPACITY:  cfg_next.min_opacity  = pwdata[7:0];
                srr_pkg::REG_FIRST_ROW:    cfg_next.first_row    = pwdata[9:0];
                srr_pkg::REG_ROW_COUNT:    cfg_next.row_count    = pwdata[10:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x     <= 15'sd0;
            cfg_reg.origin_y     <= 15'sd0;
            cfg_reg.scale        <= 8'd1;
            cfg_reg.flip_x       <= 1'b0;
            cfg_reg.sprite_width <= 11'd16;
            cfg_reg.min_opacity  <= 8'd2;
            cfg_reg.first_row    <= 10'd0;
            cfg_reg.row_count    <= 11'd1024;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            srr_pkg::REG_ORIGIN_X:     prdata[14:0] = cfg_reg.origin_x;
            srr_pkg::REG_ORIGIN_Y:     prdata[14:0] = cfg_reg.origin_y;
            srr_pkg::REG_SCALE:        prdata[7:0]  = cfg_reg.scale;
            srr_pkg::REG_FLIP_X:       prdata[0]    = cfg_reg.flip_x;
            srr_pkg::REG_SPRITE_WIDTH: prdata[10:0] = cfg_reg.sprite_width;
            srr_pkg::REG_MIN_OPACITY:  prdata[7:0]  = cfg_reg.min_opacity;
            srr_pkg::REG_FIRST_ROW:    prdata[9:0]  = cfg_reg.first_row;
            srr_pkg::REG_ROW_COUNT:    prdata[10:0] = cfg_reg.row_count;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/srr_run_tracker.sv @@
// Run tracker: holds the open run and the row/column position, and closes runs
// into up to two rectangle descriptors per pixel. Depends on srr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srr_run_tracker #(
    parameter int MAX_WIDTH  = srr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = srr_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire srr_pkg::srr_cfg_t cfg,
    input  wire logic              fire,
    input  wire logic [7:0]        pixel_opacity,
    input  wire logic [15:0]       pixel_color,
    input  wire logic              end_of_sprite,
    output srr_pkg::srr_pair_t     pair
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WSW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RCW = (RW > srr_pkg::COORD_W) ? RW : srr_pkg::COORD_W;
    localparam logic [WSW-1:0] MAX_W    = WSW'(MAX_WIDTH);
    localparam logic [RW-1:0]  ROW_LAST = RW'(MAX_HEIGHT - 1);

    logic          run_active_reg, run_active_next;
    logic [CW-1:0] run_start_reg, run_start_next;
    logic [15:0]   run_color_reg, run_color_next;
    logic [7:0]    run_opacity_reg, run_opacity_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [WSW-1:0] sw_ext, w_full, w_m1;
    logic [CW-1:0]  w_last, c, c_m1;
    logic           act_eff, visible, close1, act2, start_new, act3, row_end;
    logic           drawable, emit1, emit2;
    logic [RCW-1:0] row_ext, fr_ext, rc_ext, trow_ext;
    logic [CW-1:0]  s1, e1, s2, e2;
    srr_pkg::srr_desc_t desc1, desc2;

    always_comb begin
        // Clamp the width into 1..MAX_WIDTH.
        sw_ext = WSW'(cfg.sprite_width);
        if (sw_ext == '0) begin
            w_full = WSW'(1);
        end else if (sw_ext > MAX_W) begin
            w_full = MAX_W;
        end else begin
            w_full = sw_ext;
        end
        w_m1   = w_full - WSW'(1);
        w_last = w_m1[CW-1:0];

        // Width shrank under the column: pin to last column, drop stale run.
        c       = col_reg;
        act_eff = run_active_reg;
        if (col_reg > w_last) begin
            c = w_last;
            if (run_start_reg >= w_last) begin
                act_eff = 1'b0;
            end
        end
        c_m1 = c - CW'(1);

        visible  = pixel_opacity > cfg.min_opacity;
        row_ext  = RCW'(row_reg);
        fr_ext   = RCW'(cfg.first_row);
        rc_ext   = RCW'(cfg.row_count);
        trow_ext = row_ext - fr_ext;
        drawable = (cfg.scale != 8'd0) && (row_ext >= fr_ext) && (trow_ext < rc_ext);

        close1 = act_eff && (!visible || pixel_opacity != run_opacity_reg
                             || pixel_color != run_color_reg);
        act2      = act_eff && !close1;
        start_new = visible && !act2;
        act3      = act2 || visible;

        run_start_next   = start_new ? c : run_start_reg;
        run_color_next   = start_new ? pixel_color : run_color_reg;
        run_opacity_next = start_new ? pixel_opacity : run_opacity_reg;

        row_end = end_of_sprite || (c == w_last);
        emit1   = close1 && drawable;
        emit2   = row_end && act3 && drawable;

        if (row_end) begin
            run_active_next = 1'b0;
            col_next        = '0;
            if (end_of_sprite || row_reg == ROW_LAST) begin
                row_next = '0;
            end else begin
                row_next = row_reg + RW'(1);
            end
        end else begin
            run_active_next = act3;
            col_next        = c + CW'(1);
            row_next        = row_reg;
        end

        // Mirror across the sprite width when flipped.
        s1 = cfg.flip_x ? w_last - c_m1 : run_start_reg;
        e1 = cfg.flip_x ? w_last - run_start_reg : c_m1;
        s2 = cfg.flip_x ? w_last - c : run_start_next;
        e2 = cfg.flip_x ? w_last - run_start_next : c;

        desc1.left    = srr_pkg::COORD_W'(s1);
        desc1.right   = srr_pkg::COORD_W'(e1);
        desc1.trow    = trow_ext[srr_pkg::COORD_W-1:0];
        desc1.color   = run_color_reg;
        desc1.opacity = run_opacity_reg;
        desc1.last    = !emit2;

        desc2.left    = srr_pkg::COORD_W'(s2);
        desc2.right   = srr_pkg::COORD_W'(e2);
        desc2.trow    = trow_ext[srr_pkg::COORD_W-1:0];
        desc2.color   = run_color_next;
        desc2.opacity = run_opacity_next;
        desc2.last    = 1'b1;

        pair.cnt = {1'b0, emit1} + {1'b0, emit2};
        pair.d0  = emit1 ? desc1 : desc2;
        pair.d1  = desc2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_active_reg  <= 1'b0;
            run_start_reg   <= '0;
            run_color_reg   <= '0;
            run_opacity_reg <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
        end else if (fire) begin
            run_active_reg  <= run_active_next;
            run_start_reg   <= run_start_next;
            run_color_reg   <= run_color_next;
            run_opacity_reg <= run_opacity_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/srr_rect_emit.sv @@
// Rectangle emitter: holds the descriptors of one request, scales and places
// them into the result register, one per cycle while m_ready allows. Depends on srr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srr_rect_emit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire srr_pkg::srr_cfg_t            cfg,
    input  wire srr_pkg::srr_pair_t           pair_in,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [srr_pkg::SCREEN_W-1:0] m_x_left,
    output logic signed [srr_pkg::SCREEN_W-1:0] m_y_top,
    output logic signed [srr_pkg::SCREEN_W-1:0] m_x_right,
    output logic signed [srr_pkg::SCREEN_W-1:0] m_y_bottom,
    output logic [15:0]                       m_fill_color,
    output logic [7:0]                        m_fill_opacity,
    output logic                              m_last_of_item
);

    localparam int SW = srr_pkg::SCREEN_W;

    srr_pkg::srr_pair_t pair_reg, pair_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_load, in_fire;

    logic [SW-1:0] ox, oy, s, l_ext, r1_ext, t_ext;
    logic [SW-1:0] xl_next, xr_next, yt_next, yb_next;
    logic [SW-1:0] xl_reg, xr_reg, yt_reg, yb_reg;
    logic [15:0]   color_reg;
    logic [7:0]    opacity_reg;
    logic          last_reg;

    assign out_load = (pair_reg.cnt != 2'd0) && (!m_valid_reg || m_ready);
    assign in_ready = (pair_reg.cnt == 2'd0) || (pair_reg.cnt == 2'd1 && out_load);
    assign in_fire  = in_valid && in_ready;

    always_comb begin
        pair_next = pair_reg;
        if (in_fire) begin
            pair_next = pair_in;
        end else if (out_load) begin
            pair_next.d0  = pair_reg.d1;
            pair_next.cnt = pair_reg.cnt - 2'd1;
        end
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    // Screen math wraps to 20 bits, so all of it runs modulo 2^20.
    always_comb begin
        ox      = SW'(cfg.origin_x);
        oy      = SW'(cfg.origin_y);
        s       = SW'(cfg.scale);
        l_ext   = SW'(pair_reg.d0.left);
        r1_ext  = SW'(pair_reg.d0.right) + SW'(1);
        t_ext   = SW'(pair_reg.d0.trow);
        xl_next = ox + l_ext * s;
        xr_next = ox + r1_ext * s - SW'(1);
        yt_next = oy + t_ext * s;
        yb_next = yt_next + s - SW'(1);
    end

    always_ff @(posedge aclk) begin
        pair_reg.d0 <= pair_next.d0;
        pair_reg.d1 <= pair_next.d1;
        if (!aresetn) begin
            pair_reg.cnt <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            pair_reg.cnt <= pair_next.cnt;
            m_valid_reg  <= m_valid_next;
        end
        if (out_load) begin
            xl_reg      <= xl_next;
            xr_reg      <= xr_next;
            yt_reg      <= yt_next;
            yb_reg      <= yb_next;
            color_reg   <= pair_reg.d0.color;
            opacity_reg <= pair_reg.d0.opacity;
            last_reg    <= pair_reg.d0.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_x_left       = $signed(xl_reg);
    assign m_x_right      = $signed(xr_reg);
    assign m_y_top        = $signed(yt_reg);
    assign m_y_bottom     = $signed(yb_reg);
    assign m_fill_color   = color_reg;
    assign m_fill_opacity = opacity_reg;
    assign m_last_of_item = last_reg;

endmodule

`default_nettype wire

@@ tb/sv/srr_checker.sv @@
// Rectangle checker for the sprite row run to rectangle unit.
// Watches the register port and both streams, predicts every rectangle and compares it.
// Depends on srr_pkg.
`timescale 1ns / 1ps

module srr_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [srr_pkg::ADDR_W-1:0]  paddr,
    input  logic [srr_pkg::DATA_W-1:0]  pwdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [7:0]                  s_pixel_opacity,
    input  logic [15:0]                 s_pixel_color,
    input  logic                        s_end_of_sprite,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [19:0]                 m_x_left,
    input  logic [19:0]                 m_y_top,
    input  logic [19:0]                 m_x_right,
    input  logic [19:0]                 m_y_bottom,
    input  logic [15:0]                 m_fill_color,
    input  logic [7:0]                  m_fill_opacity,
    input  logic                        m_last_of_item,
    output int                          mismatch_count,
    output int                          rects_pending,
    output int                          rects_checked
);
    import srr_pkg::*;

    typedef struct packed {
        logic [19:0] x_left;
        logic [19:0] y_top;
        logic [19:0] x_right;
        logic [19:0] y_bottom;
        logic [15:0] color;
        logic [7:0]  opacity;
        logic        last;
    } rect_t;

    srr_cfg_t    cfg;
    logic        run_active;
    int unsigned run_start;
    logic [15:0] run_color;
    logic [7:0]  run_opacity;
    int unsigned col_cnt;
    int unsigned row_cnt;

    rect_t       pending_rects[$];
    int          fails = 0;
    int          checked = 0;

    assign mismatch_count = fails;
    assign rects_checked  = checked;

    function automatic void reset_model();
        cfg              = '0;
        cfg.scale        = 8'd1;
        cfg.sprite_width = 11'd16;
        cfg.min_opacity  = 8'd2;
        cfg.row_count    = 11'd1024;
        run_active       = 1'b0;
        run_start        = 0;
        run_color        = '0;
        run_opacity      = '0;
        col_cnt          = 0;
        row_cnt          = 0;
    endfunction

    function automatic void write_shadow(input logic [ADDR_W-1:0] addr,
                                         input logic [DATA_W-1:0] data);
        case (srr_reg_e'(addr[4:2]))
            REG_ORIGIN_X:     cfg.origin_x     = data[14:0];
            REG_ORIGIN_Y:     cfg.origin_y     = data[14:0];
            REG_SCALE:        cfg.scale        = data[7:0];
            REG_FLIP_X:       cfg.flip_x       = data[0];
            REG_SPRITE_WIDTH: cfg.sprite_width = data[10:0];
            REG_MIN_OPACITY:  cfg.min_opacity  = data[7:0];
            REG_FIRST_ROW:    cfg.first_row    = data[9:0];
            REG_ROW_COUNT:    cfg.row_count    = data[10:0];
            default: ;
        endcase
    endfunction

    // Screen bounds of the run that is closing, using the registers as they are now.
    function automatic rect_t make_rect(input int unsigned w, input int unsigned first_col,
                                        input int unsigned last_col, input int unsigned trow);
        longint lo, hi, s, ox, oy, t;
        rect_t  r;
        lo = first_col;
        hi = last_col;
        if (cfg.flip_x) begin
            lo = w - 1 - last_col;
            hi = w - 1 - first_col;
        end
        s  = cfg.scale;
        ox = $signed(cfg.origin_x);
        oy = $signed(cfg.origin_y);
        t  = trow;
        r.x_left   = 20'(ox + lo * s);
        r.y_top    = 20'(oy + t * s);
        r.x_right  = 20'(ox + (hi + 1) * s - 1);
        r.y_bottom = 20'(oy + (t + 1) * s - 1);
        r.color    = run_color;
        r.opacity  = run_opacity;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic void predict_pixel(input logic [7:0] op, input logic [15:0] color,
                                          input logic eos);
        int unsigned w, c, trow;
        bit          visible, drawable, row_end;
        rect_t       made[$];
        w = cfg.sprite_width;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;

        // Width shrank under the column: clamp, drop a run that no longer fits.
        c = col_cnt;
        if (c > w - 1) begin
            c = w - 1;
            if (run_active && run_start >= c) run_active = 1'b0;
        end

        visible  = op > cfg.min_opacity;
        trow     = row_cnt - cfg.first_row;
        drawable = cfg.scale != 0 && row_cnt >= cfg.first_row && trow < cfg.row_count;

        if (run_active && (!visible || op != run_opacity || color != run_color)) begin
            if (drawable) made.push_back(make_rect(w, run_start, c - 1, trow));
            run_active = 1'b0;
        end
        if (visible && !run_active) begin
            run_active  = 1'b1;
            run_start   = c;
            run_color   = color;
            run_opacity = op;
        end

        row_end = eos || c == w - 1;
        if (row_end) begin
            if (run_active && drawable) made.push_back(make_rect(w, run_start, c, trow));
            run_active = 1'b0;
            col_cnt    = 0;
            row_cnt    = eos ? 0 : (row_cnt + 1) % MAX_HEIGHT_DEF;
        end else begin
            col_cnt = c + 1;
        end

        if (made.size() != 0) made[made.size() - 1].last = 1'b1;
        foreach (made[i]) pending_rects.push_back(made[i]);
    endfunction

    function automatic string show(input rect_t r);
        return $sformatf("x %0d..%0d y %0d..%0d color %h opacity %0d last %0b",
                         $signed(r.x_left), $signed(r.x_right), $signed(r.y_top),
                         $signed(r.y_bottom), r.color, r.opacity, r.last);
    endfunction

    function automatic void check_rect();
        rect_t got, want;
        got.x_left   = m_x_left;
        got.y_top    = m_y_top;
        got.x_right  = m_x_right;
        got.y_bottom = m_y_bottom;
        got.color    = m_fill_color;
        got.opacity  = m_fill_opacity;
        got.last     = m_last_of_item;
        checked++;
        if (pending_rects.size() == 0) begin
            if (fails < 10) $display("unexpected rectangle: %s", show(got));
            fails++;
        end else begin
            want = pending_rects.pop_front();
            if (got !== want) begin
                if (fails < 10)
                    $display("rectangle mismatch\n  expected %s\n  actual   %s",
                             show(want), show(got));
                fails++;
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
            pending_rects.delete();
        end else begin
            if (psel && penable && pwrite && pready) write_shadow(paddr, pwdata);
            if (m_valid && m_ready) check_rect();
            if (s_valid && s_ready)
                predict_pixel(s_pixel_opacity, s_pixel_color, s_end_of_sprite);
        end
        rects_pending <= pending_rects.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the sprite row run to rectangle testbench: clock, reset, stimulus and verdict.
// Instantiates sprite_row_run_to_rectangles_unit and srr_checker; uses srr_pkg.
`timescale 1ns / 1ps

module testbench;
    import srr_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 psel, penable, pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_valid, s_ready;
    logic [7:0]           s_pixel_opacity;
    logic [15:0]          s_pixel_color;
    logic                 s_end_of_sprite;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [19:0]   m_x_left, m_y_top, m_x_right, m_y_bottom;
    logic [15:0]          m_fill_color;
    logic [7:0]           m_fill_opacity;
    logic                 m_last_of_item;

    int mismatch_count, rects_pending, rects_checked;

    // Percent chance per request (sender) or per cycle (receiver) that an idle burst starts.
    int idle_pct     = 10;
    int stall_left   = 0;
    int pixels_sent  = 0;
    int settings_run = 0;
    int min_op_now   = 2;

    logic [15:0] palette[4] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0};

    always #6 aclk = ~aclk;

    sprite_row_run_to_rectangles_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_opacity (s_pixel_opacity),
        .s_pixel_color   (s_pixel_color),
        .s_end_of_sprite (s_end_of_sprite),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_x_left        (m_x_left),
        .m_y_top         (m_y_top),
        .m_x_right       (m_x_right),
        .m_y_bottom      (m_y_bottom),
        .m_fill_color    (m_fill_color),
        .m_fill_opacity  (m_fill_opacity),
        .m_last_of_item  (m_last_of_item)
    );

    srr_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_opacity (s_pixel_opacity),
        .s_pixel_color   (s_pixel_color),
        .s_end_of_sprite (s_end_of_sprite),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_x_left        (m_x_left),
        .m_y_top         (m_y_top),
        .m_x_right       (m_x_right),
        .m_y_bottom      (m_y_bottom),
        .m_fill_color    (m_fill_color),
        .m_fill_opacity  (m_fill_opacity),
        .m_last_of_item  (m_last_of_item),
        .mismatch_count  (mismatch_count),
        .rects_pending   (rects_pending),
        .rects_checked   (rects_checked)
    );

    // Result side back-pressure: drop m_ready for bursts of random length.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            stall_left <= $urandom_range(0, 18);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one pixel request and hold it until accepted. Entered right after an edge.
    task automatic send_pixel(input logic [7:0] op, input logic [15:0] color,
                              input logic eos);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_pixel_opacity <= op;
        s_pixel_color   <= color;
        s_end_of_sprite <= eos;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    // Stop sending and wait until every predicted rectangle has come back,
    // then idle before returning so anything still in flight can flush.
    task automatic drain_rects();
        s_valid <= 1'b0;
        do @(posedge aclk); while (rects_pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    // psel stays high so back-to-back writes need no idle between them; release afterwards.
    task automatic set_reg(input srr_reg_e r, input int v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_setting(input int ox, input int oy, input int sc, input int fl,
                                   input int w, input int mo, input int fr, input int rc);
        drain_rects();
        set_reg(REG_ORIGIN_X, ox);
        set_reg(REG_ORIGIN_Y, oy);
        set_reg(REG_SCALE, sc);
        set_reg(REG_FLIP_X, fl);
        set_reg(REG_SPRITE_WIDTH, w);
        set_reg(REG_MIN_OPACITY, mo);
        set_reg(REG_FIRST_ROW, fr);
        set_reg(REG_ROW_COUNT, rc);
        apb_release();
        min_op_now = mo;
        settings_run++;
    endtask

    // Runs of 1 to 6 equal pixels; some runs sit at or below the opacity floor,
    // some use an arbitrary color so every color bit toggles.
    task automatic send_runs(input int count, input int eos_pct);
        int          run_left;
        logic [7:0]  op;
        logic [15:0] color;
        run_left = 0;
        op       = '0;
        color    = '0;
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(1, 6);
                case ($urandom_range(0, 7))
                    0:       op = 8'($urandom_range(0, min_op_now));
                    1:       op = 8'hFF;
                    default: op = 8'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 3) == 0) color = 16'($urandom);
                else color = palette[$urandom_range(0, 3)];
            end
            run_left--;
            send_pixel(op, color, $urandom_range(1, 100) <= eos_pct);
        end
    endtask

    task automatic random_setting();
        int sc, w, mo, fr, rc;
        case ($urandom_range(0, 7))
            0:       sc = 0;
            1:       sc = 255;
            default: sc = $urandom_range(1, 4);
        endcase
        w  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 20);
        mo = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        fr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 4);
        rc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 8);
        program_setting($urandom_range(0, 32767), $urandom_range(0, 32767), sc,
                        $urandom_range(0, 1), w, mo, fr, rc);
    endtask

    initial begin
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_pixel_opacity = '0;
        s_pixel_color   = '0;
        s_end_of_sprite = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: width 16, opacity floor 2, scale 1, origin 0.
        // Row 0 walks through opacity changes, color changes, pixels at and
        // below the floor, and a last-column pixel that closes two runs.
        send_pixel(8'd255, 16'hFFFF, 1'b0);
        send_pixel(8'd255, 16'hFFFF, 1'b0);
        send_pixel(8'd3,   16'hFFFF, 1'b0);
        send_pixel(8'd2,   16'h0000, 1'b0);
        send_pixel(8'd0,   16'h0000, 1'b0);
        send_pixel(8'd128, 16'h0000, 1'b0);
        send_pixel(8'd128, 16'h0001, 1'b0);
        send_pixel(8'd128, 16'h0001, 1'b0);
        send_pixel(8'd1,   16'hAAAA, 1'b0);
        send_pixel(8'd255, 16'h5555, 1'b0);
        send_pixel(8'd255, 16'h5555, 1'b0);
        send_pixel(8'd255, 16'h8000, 1'b0);
        send_pixel(8'd254, 16'h8000, 1'b0);
        send_pixel(8'd200, 16'h7FFF, 1'b0);
        send_pixel(8'd200, 16'h7FFF, 1'b0);
        send_pixel(8'd200, 16'hF800, 1'b0);
        // Row 1 ends early on the end-of-sprite pixel with a run open.
        send_pixel(8'd255, 16'h07E0, 1'b0);
        send_pixel(8'd255, 16'h07E0, 1'b1);
        // One-pixel sprite, then end-of-sprite on a skipped pixel.
        send_pixel(8'd9,   16'h001F, 1'b1);
        send_pixel(8'd255, 16'hFFFF, 1'b0);
        send_pixel(8'd0,   16'h0000, 1'b1);

        // Extreme origins, largest scale, mirrored, no opacity floor.
        program_setting(-16384, 16383, 255, 1, 7, 0, 0, 1024);
        send_runs(40, 3);
        // Scale 0 draws nothing while runs are still tracked.
        program_setting(16383, -16384, 0, 0, 16, 2, 0, 1024);
        send_runs(20, 3);
        // Width 0 behaves as one column: every visible pixel is its own rectangle.
        program_setting(0, 0, 1, 0, 0, 0, 0, 1024);
        send_runs(15, 5);
        // Width above the limit clamps; floor 254 lets only opaque pixels through.
        program_setting(-1, 1, 2, 1, 2047, 254, 0, 1024);
        send_runs(20, 5);
        // Narrow row window.
        program_setting(-5, 9, 2, 0, 4, 2, 2, 3);
        send_runs(60, 2);
        // row_count 0 draws no row at all.
        program_setting(0, 0, 1, 0, 4, 2, 1023, 0);
        send_runs(20, 3);

        // Width shrinks under an open run that still fits: it closes short.
        program_setting(3, 4, 2, 0, 12, 2, 0, 1024);
        send_pixel(8'd0, 16'h0000, 1'b1);
        repeat (9) send_pixel(8'd255, 16'h1234, 1'b0);
        drain_rects();
        set_reg(REG_SPRITE_WIDTH, 5);
        apb_release();
        send_pixel(8'd255, 16'h4321, 1'b0);
        // Width shrinks below the start of an open run: the run is dropped.
        drain_rects();
        set_reg(REG_SPRITE_WIDTH, 12);
        apb_release();
        repeat (6) send_pixel(8'd0, 16'h0000, 1'b0);
        repeat (3) send_pixel(8'd200, 16'hBEEF, 1'b0);
        drain_rects();
        set_reg(REG_SPRITE_WIDTH, 4);
        set_reg(REG_FLIP_X, 1);
        apb_release();
        send_pixel(8'd200, 16'hBEEF, 1'b0);

        // One-column rows under a row window that opens a few rows in.
        program_setting(100, -200, 3, 1, 1, 2, 3, 2047);
        send_runs(40, 0);

        // Random settings with random well-formed runs; the final one without idling.
        for (int k = 0; k < 9; k++) begin
            idle_pct = (k == 8) ? 0 : 5 * $urandom_range(0, 6);
            random_setting();
            send_runs(16, 3);
        end

        drain_rects();
        $display("Sent %0d pixel requests under %0d register settings, checked %0d rectangles.",
                 pixels_sent, settings_run, rects_checked);
        $display("Covered flip, scale 0 and 255, width clamps, row windows and width shrink.");
        if (mismatch_count == 0 && rects_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout: run did not complete");
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/srr_pkg.sv
rtl/srr_cfg_regs.sv
rtl/srr_run_tracker.sv
rtl/srr_rect_emit.sv
rtl/sprite_row_run_to_rectangles_unit.sv
tb/sv/srr_checker.sv
tb/sv/testbench.sv
